// File: sv/ssie_pkg.sv
// Shared types and constants for the shuffle split index engine.
// No dependencies; every other file in sv/ refers to it by scoped names.
`default_nettype none

package ssie_pkg;

   // table geometry
   localparam int DEPTH   = 1024;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = IDX_W + 1;

   // request and configuration widths
   localparam int WORD_W  = 32;
   localparam int FRAC_W  = 17;
   localparam int Q_SHIFT = 16;
   localparam int PROD_W  = FRAC_W + CNT_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = FRAC_W;

   localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(1 << Q_SHIFT);

   // register reset values
   localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST   = CNT_W'(DEPTH);
   localparam logic [FRAC_W-1:0] TRAIN_FRACTION_RST = FRAC_W'(1 << (Q_SHIFT - 1));

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIN_FRACTION = 1'b1;

   // action codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_SWAP  = 2'd1;
   localparam logic [1:0] ACT_TRAIN = 2'd2;
   localparam logic [1:0] ACT_TEST  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_NOSWAP = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load_req;
      logic       init;
      logic       fill_write;
      logic       div_start;
      logic       swap_read;
      logic       table_read;
      logic       write_i;
      logic       write_j;
      logic       capture;
      logic       status_wr;
      logic [1:0] status_code;
      logic       respond;
   } ssie_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] action;
      logic       swap_ok;
      logic       read_ok;
      logic       fill_done;
      logic       div_done;
   } ssie_stat_type;

endpackage

`default_nettype wire

// File: sv/ssie_mod_unit.sv
// Iterative remainder unit: random word modulo swap counter, one bit per cycle.
// Depends on ssie_pkg for widths.
`default_nettype none

module ssie_mod_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        div_start,
   input  wire logic [ssie_pkg::WORD_W-1:0] dividend,
   input  wire logic [ssie_pkg::CNT_W-1:0]  divisor,
   output logic                             div_done,
   output logic [ssie_pkg::IDX_W-1:0]       remainder
);

   localparam int STEP_W = $clog2(ssie_pkg::WORD_W);

   logic [ssie_pkg::WORD_W-1:0] quo_ff, quo_in;
   logic [ssie_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [ssie_pkg::CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [ssie_pkg::CNT_W:0]    trial;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[ssie_pkg::WORD_W-1]};
      if (div_start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(ssie_pkg::WORD_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[ssie_pkg::WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = ssie_pkg::CNT_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[ssie_pkg::CNT_W-1:0];
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign div_done  = done_ff;
   assign remainder = rem_ff[ssie_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

// File: sv/ssie_datapath.sv
// Datapath: configuration registers, counters, order table memory and result registers.
// Depends on ssie_pkg and ssie_mod_unit.
`default_nettype none

module ssie_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ssie_pkg::ssie_cmd_type           cmd,
   output ssie_pkg::ssie_stat_type               stat,
   input  wire logic [1:0]                       req_action,
   input  wire logic [ssie_pkg::WORD_W-1:0]      req_random_word,
   input  wire logic [ssie_pkg::IDX_W-1:0]       req_position,
   input  wire logic                             csr_write,
   input  wire logic [ssie_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ssie_pkg::CSR_DAT_W-1:0]   csr_data,
   output logic                                  rsp_valid,
   output logic [ssie_pkg::IDX_W-1:0]            rsp_sample_index,
   output logic [ssie_pkg::CNT_W-1:0]            rsp_train_count,
   output logic [ssie_pkg::CNT_W-1:0]            rsp_test_count,
   output logic [ssie_pkg::CNT_W-1:0]            rsp_swaps_left,
   output logic [1:0]                            rsp_status
);

   localparam int IW = ssie_pkg::IDX_W;
   localparam int CW = ssie_pkg::CNT_W;
   localparam int FW = ssie_pkg::FRAC_W;
   localparam int PW = ssie_pkg::PROD_W;

   // configuration
   logic [CW-1:0] sample_count_ff;
   logic [FW-1:0] train_fraction_ff;

   // state
   logic [CW-1:0] swap_counter_ff, swap_counter_in;
   logic [CW-1:0] train_total_ff, train_total_in;
   logic [CW-1:0] latched_n_ff, latched_n_in;
   logic [CW-1:0] fill_cnt_ff, fill_cnt_in;

   // latched request and per-item result
   logic [1:0]               action_ff;
   logic [ssie_pkg::WORD_W-1:0] rword_ff;
   logic [IW-1:0]            pos_ff;
   logic [IW-1:0]            sample_ff;
   logic [1:0]               status_ff;

   // table memory
   logic [IW-1:0] order_mem [ssie_pkg::DEPTH];
   logic [IW-1:0] rd_a_ff, rd_b_ff;
   logic [IW-1:0] rd_a_addr, wr_addr, wr_data;
   logic          wr_en;

   // result registers
   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_sample_ff;
   logic [CW-1:0] rsp_train_ff, rsp_test_ff, rsp_swaps_ff;
   logic [1:0]    rsp_status_ff;

   logic [CW-1:0] n_sat, test_total;
   logic [FW-1:0] f_sat;
   logic [PW-1:0] product;
   logic [IW-1:0] i_addr, j_idx, read_addr;
   logic          div_done;

   // remainder unit
   ssie_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .div_start (cmd.div_start),
      .dividend  (rword_ff),
      .divisor   (swap_counter_ff),
      .div_done  (div_done),
      .remainder (j_idx)
   );

   // derived values
   always_comb begin
      n_sat      = (sample_count_ff > CW'(ssie_pkg::DEPTH)) ? CW'(ssie_pkg::DEPTH)
                                                            : sample_count_ff;
      f_sat      = (train_fraction_ff > ssie_pkg::Q16_ONE) ? ssie_pkg::Q16_ONE
                                                           : train_fraction_ff;
      product    = PW'(f_sat) * PW'(n_sat);
      test_total = latched_n_ff - train_total_ff;
      i_addr     = IW'(swap_counter_ff - 1'b1);
      if (action_ff == ssie_pkg::ACT_TRAIN) begin
         read_addr = pos_ff;
      end else begin
         read_addr = IW'(train_total_ff + CW'(pos_ff));
      end
   end

   // status toward the controller
   always_comb begin
      stat.action    = action_ff;
      stat.swap_ok   = swap_counter_ff > CW'(1);
      stat.fill_done = fill_cnt_ff == latched_n_ff;
      stat.div_done  = div_done;
      if (action_ff == ssie_pkg::ACT_TRAIN) begin
         stat.read_ok = CW'(pos_ff) < train_total_ff;
      end else begin
         stat.read_ok = CW'(pos_ff) < test_total;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff   <= ssie_pkg::SAMPLE_COUNT_RST;
         train_fraction_ff <= ssie_pkg::TRAIN_FRACTION_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            ssie_pkg::CSR_SAMPLE_COUNT:   sample_count_ff   <= csr_data[CW-1:0];
            ssie_pkg::CSR_TRAIN_FRACTION: train_fraction_ff <= csr_data[FW-1:0];
            default: ;
         endcase
      end
   end

   // next values of counters
   always_comb begin
      swap_counter_in = swap_counter_ff;
      train_total_in  = train_total_ff;
      latched_n_in    = latched_n_ff;
      fill_cnt_in     = fill_cnt_ff;
      if (cmd.init) begin
         latched_n_in    = n_sat;
         swap_counter_in = n_sat;
         train_total_in  = product[ssie_pkg::Q_SHIFT +: CW];
         fill_cnt_in     = '0;
      end
      if (cmd.fill_write) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
      end
      if (cmd.write_j) begin
         swap_counter_in = swap_counter_ff - 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_counter_ff <= '0;
         train_total_ff  <= '0;
         latched_n_ff    <= '0;
         fill_cnt_ff     <= '0;
      end else begin
         swap_counter_ff <= swap_counter_in;
         train_total_ff  <= train_total_in;
         latched_n_ff    <= latched_n_in;
         fill_cnt_ff     <= fill_cnt_in;
      end
   end

   // latch the request, track the item's sample and status
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         rword_ff  <= req_random_word;
         pos_ff    <= req_position;
         sample_ff <= '0;
         status_ff <= ssie_pkg::ST_OK;
      end else begin
         if (cmd.capture) begin
            sample_ff <= rd_a_ff;
         end
         if (cmd.status_wr) begin
            status_ff <= cmd.status_code;
         end
      end
   end

   // memory port selection
   always_comb begin
      rd_a_addr = cmd.table_read ? read_addr : i_addr;
      wr_en     = cmd.fill_write | cmd.write_i | cmd.write_j;
      if (cmd.fill_write) begin
         wr_addr = fill_cnt_ff[IW-1:0];
         wr_data = fill_cnt_ff[IW-1:0];
      end else if (cmd.write_i) begin
         wr_addr = i_addr;
         wr_data = rd_b_ff;
      end else begin
         wr_addr = j_idx;
         wr_data = rd_a_ff;
      end
   end

   // order table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         order_mem[wr_addr] <= wr_data;
      end
      if (cmd.table_read | cmd.swap_read) begin
         rd_a_ff <= order_mem[rd_a_addr];
      end
      if (cmd.swap_read) begin
         rd_b_ff <= order_mem[j_idx];
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_sample_ff <= sample_ff;
         rsp_train_ff  <= train_total_ff;
         rsp_test_ff   <= test_total;
         rsp_swaps_ff  <= swap_counter_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_index = rsp_sample_ff;
   assign rsp_train_count  = rsp_train_ff;
   assign rsp_test_count   = rsp_test_ff;
   assign rsp_swaps_left   = rsp_swaps_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// File: sv/ssie_ctrl.sv
// Controller state machine: sequences fill, swap and read items over the datapath.
// Depends on ssie_pkg.
`default_nettype none

module ssie_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire ssie_pkg::ssie_stat_type stat,
   output ssie_pkg::ssie_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_FILL     = 3'd2;
   localparam logic [2:0] S_DIV      = 3'd3;
   localparam logic [2:0] S_SWAP_I   = 3'd4;
   localparam logic [2:0] S_SWAP_J   = 3'd5;
   localparam logic [2:0] S_READ     = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.action) inside
               ssie_pkg::ACT_START: begin
                  cmd.init = 1'b1;
                  state_in = S_FILL;
               end
               ssie_pkg::ACT_SWAP: begin
                  if (stat.swap_ok) begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end else begin
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = ssie_pkg::ST_NOSWAP;
                     state_in        = S_RESP;
                  end
               end
               ssie_pkg::ACT_TRAIN, ssie_pkg::ACT_TEST: begin
                  if (stat.read_ok) begin
                     cmd.table_read = 1'b1;
                     state_in       = S_READ;
                  end else begin
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = ssie_pkg::ST_RANGE;
                     state_in        = S_RESP;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_FILL: begin
            if (stat.fill_done) begin
               state_in = S_RESP;
            end else begin
               cmd.fill_write = 1'b1;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.swap_read = 1'b1;
               state_in      = S_SWAP_I;
            end
         end
         S_SWAP_I: begin
            cmd.write_i = 1'b1;
            state_in    = S_SWAP_J;
         end
         S_SWAP_J: begin
            cmd.write_j = 1'b1;
            state_in    = S_RESP;
         end
         S_READ: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

`default_nettype wire

// File: sv/shuffle_split_index_engine.sv
// Shuffle split index engine: a permutation table shuffled one swap per item and read
// per partition. A start item fills min(sample_count, 1024) table entries, one entry per
// cycle, before its result strobe. A swap item runs the 32-step remainder unit, then one
// read and two writes on the table memory. The result is shown for exactly one cycle on
// rsp_valid and cannot be held off; busy is low again in that same cycle, so the next
// item may be started then. Configuration writes are taken while busy is low.
`default_nettype none

module shuffle_split_index_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_action,
   input  wire logic [ssie_pkg::WORD_W-1:0]      req_random_word,
   input  wire logic [ssie_pkg::IDX_W-1:0]       req_position,
   output logic                                  rsp_valid,
   output logic [ssie_pkg::IDX_W-1:0]            rsp_sample_index,
   output logic [ssie_pkg::CNT_W-1:0]            rsp_train_count,
   output logic [ssie_pkg::CNT_W-1:0]            rsp_test_count,
   output logic [ssie_pkg::CNT_W-1:0]            rsp_swaps_left,
   output logic [1:0]                            rsp_status,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ssie_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ssie_pkg::CSR_DAT_W-1:0]   csr_data
);

   ssie_pkg::ssie_cmd_type  cmd;
   ssie_pkg::ssie_stat_type stat;

   // take register writes only between items
   assign csr_ready = !busy;

   ssie_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ssie_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_random_word  (req_random_word),
      .req_position     (req_position),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_sample_index (rsp_sample_index),
      .rsp_train_count  (rsp_train_count),
      .rsp_test_count   (rsp_test_count),
      .rsp_swaps_left   (rsp_swaps_left),
      .rsp_status       (rsp_status)
   );

   // an accepted item keeps the block busy until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accepted");

   // the result strobe comes with the block idle again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // refused reads return a zero sample index
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ssie_pkg::ST_RANGE) |-> rsp_sample_index == '0)
      else $error("out-of-range read returned a sample");

   // the two partitions never exceed the table
   a_split_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((ssie_pkg::CNT_W + 1)'(rsp_train_count)
                     + (ssie_pkg::CNT_W + 1)'(rsp_test_count)
                     <= (ssie_pkg::CNT_W + 1)'(ssie_pkg::DEPTH)))
      else $error("partition sizes exceed table depth");

endmodule

`default_nettype wire

// File: bench/tb_shuffle_split_index_engine.sv
// Self-checking bench for the shuffle split index engine: directed and random items
// are checked against a cycle-free predictor of the permutation table and its counters.
// Depends on ssie_pkg and shuffle_split_index_engine from the sv folder.
`timescale 1ns / 100ps

module tb_shuffle_split_index_engine;

   localparam int IDX_W  = ssie_pkg::IDX_W;
   localparam int CNT_W  = ssie_pkg::CNT_W;
   localparam int WORD_W = ssie_pkg::WORD_W;
   localparam int FRAC_W = ssie_pkg::FRAC_W;
   localparam int TABLE_DEPTH = ssie_pkg::DEPTH;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [IDX_W-1:0] sample_index;
      logic [CNT_W-1:0] train_count;
      logic [CNT_W-1:0] test_count;
      logic [CNT_W-1:0] swaps_left;
      logic [1:0]       status;
   } split_answer_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_action;
   logic [WORD_W-1:0]             req_random_word;
   logic [IDX_W-1:0]              req_position;
   logic                          rsp_valid;
   logic [IDX_W-1:0]              rsp_sample_index;
   logic [CNT_W-1:0]              rsp_train_count;
   logic [CNT_W-1:0]              rsp_test_count;
   logic [CNT_W-1:0]              rsp_swaps_left;
   logic [1:0]                    rsp_status;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [ssie_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ssie_pkg::CSR_DAT_W-1:0] csr_data;

   // predictor state: permutation table, counters and register shadows
   logic [IDX_W-1:0]  shadow_order [TABLE_DEPTH];
   logic [CNT_W-1:0]  shuffle_left = '0;
   logic [CNT_W-1:0]  train_total = '0;
   logic [CNT_W-1:0]  latched_count = '0;
   logic [CNT_W-1:0]  cfg_sample_count = ssie_pkg::SAMPLE_COUNT_RST;
   logic [FRAC_W-1:0] cfg_train_fraction = ssie_pkg::TRAIN_FRACTION_RST;

   split_answer_type pending_answers [$];
   split_answer_type oldest_answer;
   int            error_count = 0;
   int            result_count = 0;
   int            idle_pct = 0;
   int            cycle_count = 0;

   shuffle_split_index_engine uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_random_word  (req_random_word),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_sample_index (rsp_sample_index),
      .rsp_train_count  (rsp_train_count),
      .rsp_test_count   (rsp_test_count),
      .rsp_swaps_left   (rsp_swaps_left),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // advance the permutation state by one item and return its answer
   function automatic split_answer_type apply_item(input logic [1:0] action,
                                                   input logic [WORD_W-1:0] word,
                                                   input logic [IDX_W-1:0] pos);
      split_answer_type ans;
      int unsigned   n;
      int unsigned   frac;
      int unsigned   test_total;
      int unsigned   j;
      logic [IDX_W-1:0] held;
      ans = '0;
      ans.status = ssie_pkg::ST_OK;
      case (action)
         ssie_pkg::ACT_START: begin
            n = (cfg_sample_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_sample_count;
            frac = (cfg_train_fraction > ssie_pkg::Q16_ONE) ?
                   ssie_pkg::Q16_ONE : cfg_train_fraction;
            for (int k = 0; k < n; k++) shadow_order[k] = IDX_W'(k);
            latched_count = CNT_W'(n);
            shuffle_left = CNT_W'(n);
            train_total = CNT_W'((longint'(frac) * longint'(n)) >> ssie_pkg::Q_SHIFT);
         end
         ssie_pkg::ACT_SWAP: begin
            if (shuffle_left > 1) begin
               j = word % shuffle_left;
               held = shadow_order[shuffle_left - 1];
               shadow_order[shuffle_left - 1] = shadow_order[j];
               shadow_order[j] = held;
               shuffle_left = shuffle_left - 1'b1;
            end else begin
               ans.status = ssie_pkg::ST_NOSWAP;
            end
         end
         ssie_pkg::ACT_TRAIN: begin
            if (pos < train_total) ans.sample_index = shadow_order[pos];
            else ans.status = ssie_pkg::ST_RANGE;
         end
         default: begin
            test_total = latched_count - train_total;
            if (pos < test_total) ans.sample_index = shadow_order[train_total + pos];
            else ans.status = ssie_pkg::ST_RANGE;
         end
      endcase
      ans.train_count = train_total;
      ans.test_count = latched_count - train_total;
      ans.swaps_left = shuffle_left;
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_count, what, got, want);
      error_count++;
   endtask

   // check each strobed result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            oldest_answer = pending_answers.pop_front();
            if (rsp_sample_index !== oldest_answer.sample_index)
               report_mismatch("sample_index", rsp_sample_index, oldest_answer.sample_index);
            if (rsp_train_count !== oldest_answer.train_count)
               report_mismatch("train_count", rsp_train_count, oldest_answer.train_count);
            if (rsp_test_count !== oldest_answer.test_count)
               report_mismatch("test_count", rsp_test_count, oldest_answer.test_count);
            if (rsp_swaps_left !== oldest_answer.swaps_left)
               report_mismatch("swaps_left", rsp_swaps_left, oldest_answer.swaps_left);
            if (rsp_status !== oldest_answer.status)
               report_mismatch("status", rsp_status, oldest_answer.status);
         end
         result_count++;
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // offer one item, with random gaps, and predict it once accepted
   task automatic send_item(input logic [1:0] action, input logic [WORD_W-1:0] word,
                            input logic [IDX_W-1:0] pos);
      @(negedge clock);
      while (int'($urandom_range(99)) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_action = action;
      req_random_word = word;
      req_position = pos;
      do @(posedge clock); while (busy);
      pending_answers.push_back(apply_item(action, word, pos));
   endtask

   // hold off new items until every result is back
   task automatic drain_answers();
      @(negedge clock);
      start = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [ssie_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [ssie_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == ssie_pkg::CSR_SAMPLE_COUNT) cfg_sample_count = data[CNT_W-1:0];
      else cfg_train_fraction = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // program both registers once the block is idle
   task automatic configure_split(input logic [FRAC_W-1:0] count_word,
                                  input logic [FRAC_W-1:0] fraction_word);
      drain_answers();
      write_register(ssie_pkg::CSR_SAMPLE_COUNT, count_word);
      write_register(ssie_pkg::CSR_TRAIN_FRACTION, fraction_word);
   endtask

   // mostly small tables, a few at or beyond the full depth; junk in the upper bits
   function automatic logic [FRAC_W-1:0] random_count_word();
      int unsigned roll;
      int unsigned count;
      roll = $urandom_range(99);
      if (roll < 5) count = 0;
      else if (roll < 10) count = TABLE_DEPTH;
      else if (roll < 15) count = $urandom_range(2047, TABLE_DEPTH + 1);
      else if (roll < 25) count = $urandom_range(TABLE_DEPTH, 41);
      else count = $urandom_range(40, 1);
      return {6'($urandom), 11'(count)};
   endfunction

   function automatic logic [FRAC_W-1:0] random_fraction_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 30) return ssie_pkg::Q16_ONE;
      if (roll < 40) return FRAC_W'($urandom_range(131071, 65537));
      return FRAC_W'($urandom_range(65535, 0));
   endfunction

   // nothing loaded yet: both partitions are empty and no swap is left
   task automatic test_reads_before_start();
      send_item(ssie_pkg::ACT_TRAIN, '0, 10'd0);
      send_item(ssie_pkg::ACT_TEST, '0, 10'h3FF);
      send_item(ssie_pkg::ACT_SWAP, 32'hFFFF_FFFF, 10'h3FF);
   endtask

   // oversized count clips to the depth, oversized fraction clips to one
   task automatic test_start_saturation();
      configure_split(17'h1FFFF, 17'h1FFFF);
      send_item(ssie_pkg::ACT_START, '0, 10'd0);
      send_item(ssie_pkg::ACT_TRAIN, $urandom(), 10'h3FF);
      send_item(ssie_pkg::ACT_TEST, $urandom(), 10'd0);
   endtask

   // zero samples: empty table, every read refused, no swap
   task automatic test_empty_table();
      configure_split(17'd0, 17'd32768);
      send_item(ssie_pkg::ACT_START, $urandom(), 10'h3FF);
      send_item(ssie_pkg::ACT_TRAIN, $urandom(), 10'd0);
      send_item(ssie_pkg::ACT_TEST, $urandom(), 10'd0);
      send_item(ssie_pkg::ACT_SWAP, $urandom(), 10'd0);
   endtask

   // one sample: counter starts at one, so the swap is refused
   task automatic test_single_sample();
      configure_split(17'd1, ssie_pkg::Q16_ONE);
      send_item(ssie_pkg::ACT_START, $urandom(), 10'd0);
      send_item(ssie_pkg::ACT_SWAP, 32'hFFFF_FFFF, 10'd0);
      send_item(ssie_pkg::ACT_TRAIN, $urandom(), 10'd0);
   endtask

   // all samples in test; test reads at the last entry and past it, two swaps, then a refused train read
   task automatic test_shuffle_and_reads();
      configure_split(17'd6, 17'd0);
      send_item(ssie_pkg::ACT_START, $urandom(), 10'd0);
      send_item(ssie_pkg::ACT_TEST, $urandom(), 10'd5);
      send_item(ssie_pkg::ACT_TEST, $urandom(), 10'd6);
      send_item(ssie_pkg::ACT_SWAP, 32'hFFFF_FFFF, 10'd0);
      send_item(ssie_pkg::ACT_SWAP, 32'h0000_0000, 10'd0);
      send_item(ssie_pkg::ACT_TRAIN, $urandom(), 10'd0);
   endtask

   // new registers leave the running shuffle alone until the next start
   task automatic test_late_config();
      configure_split(17'd3, ssie_pkg::Q16_ONE);
      send_item(ssie_pkg::ACT_TEST, $urandom(), 10'd5);
      repeat (4) send_item(ssie_pkg::ACT_SWAP, $urandom(), 10'($urandom));
      send_item(ssie_pkg::ACT_START, $urandom(), 10'd0);
      send_item(ssie_pkg::ACT_TRAIN, $urandom(), 10'd2);
   endtask

   // sessions of start, swaps and reads, mostly in range, on random settings
   task automatic run_random_phase(input int pct, input int item_goal);
      int          sent;
      int unsigned part;
      int unsigned roll;
      logic [1:0]  act;
      logic [IDX_W-1:0] pos;
      idle_pct = pct;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(1) == 0)
            configure_split(random_count_word(), random_fraction_word());
         send_item(ssie_pkg::ACT_START, $urandom(), IDX_W'($urandom));
         sent++;
         repeat ($urandom_range(40, 4)) begin
            roll = $urandom_range(99);
            if (roll < 55) act = ssie_pkg::ACT_SWAP;
            else if (roll < 77) act = ssie_pkg::ACT_TRAIN;
            else act = ssie_pkg::ACT_TEST;
            part = (act == ssie_pkg::ACT_TEST) ? latched_count - train_total : train_total;
            if (part > 0 && $urandom_range(9) < 8) pos = IDX_W'($urandom_range(part - 1));
            else pos = IDX_W'($urandom);
            if ($urandom_range(99) < 3) drain_answers();
            send_item(act, $urandom(), pos);
            sent++;
         end
      end
      drain_answers();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = ssie_pkg::ACT_START;
      req_random_word = '0;
      req_position = '0;
      csr_valid = 1'b0;
      csr_index = ssie_pkg::CSR_SAMPLE_COUNT;
      csr_data = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_reads_before_start();
      test_start_saturation();
      test_empty_table();
      test_single_sample();
      test_shuffle_and_reads();
      test_late_config();
      drain_answers();

      run_random_phase(9, 516);
      run_random_phase(74, 516);
      run_random_phase(0, 516);

      drain_answers();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ssie_pkg.sv
sv/ssie_mod_unit.sv
sv/ssie_datapath.sv
sv/ssie_ctrl.sv
sv/shuffle_split_index_engine.sv
bench/tb_shuffle_split_index_engine.sv
